>>> hdl/dtq_pkg.sv
// Package with the codes, widths and helpers shared by the delta timer queue.
`default_nettype none

package dtq_pkg;

    localparam int DEFAULT_QUEUE_ENTRIES = 16;
    localparam int DEFAULT_TASK_ID_BITS  = 8;
    localparam int DEFAULT_DELAY_BITS    = 16;

    localparam int DELTA_W = 24;
    localparam int REM_W   = 27;

    localparam logic signed [REM_W-1:0] DELTA_HI = REM_W'((64'sd1 <<< (DELTA_W - 1)) - 64'sd1);
    localparam logic signed [REM_W-1:0] DELTA_LO = REM_W'(-(64'sd1 <<< (DELTA_W - 1)));

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_TICK   = 2'd1,
        OP_POP    = 2'd2
    } dtq_op_t;

    typedef enum logic [2:0] {
        STAT_INSERTED = 3'd0,
        STAT_FULL     = 3'd1,
        STAT_TICKED   = 3'd2,
        STAT_NONE     = 3'd3,
        STAT_POPPED   = 3'd4
    } dtq_status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FRESH,
        ST_WALK,
        ST_WR_CUR,
        ST_WR_PREV,
        ST_HEAD,
        ST_RESP
    } dtq_state_t;

    function automatic logic signed [DELTA_W-1:0] sat_delta(input logic signed [REM_W-1:0] v);
        logic signed [DELTA_W-1:0] r;
        if (v > DELTA_HI)
        begin
            r = DELTA_HI[DELTA_W-1:0];
        end
        else if (v < DELTA_LO)
        begin
            r = DELTA_LO[DELTA_W-1:0];
        end
        else
        begin
            r = v[DELTA_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/dtq_ram.sv
// Simple dual-port entry memory with one write port and a registered read port.
`default_nettype none

module dtq_ram #(
    parameter int DEPTH  = dtq_pkg::DEFAULT_QUEUE_ENTRIES,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hdl/delta_timer_queue_unit.sv
// Top level of the delta timer queue: command sequencer around the entry memory.
//
//  Channel   Direction  Beat contents
//  s_axis    in         tuser: op; tdata: task_id, delay_ticks
//  m_axis    out        tuser: status; tdata: popped_id, entry_count
//
// A tick or pop goes from ST_HEAD to ST_RESP; a rejected or ignored command goes
// straight to ST_RESP. An insert reads its free slot in ST_FRESH; on a non-empty
// queue the walk then reads one linked entry per cycle from the single read port
// of the entry memory. After reset a clearing pass over every entry builds the
// free chain; no beat is accepted during it.
// A new command is taken while the previous result waits on m_axis.
`default_nettype none

module delta_timer_queue_unit #(
    parameter int QUEUE_ENTRIES = dtq_pkg::DEFAULT_QUEUE_ENTRIES,
    parameter int TASK_ID_BITS  = dtq_pkg::DEFAULT_TASK_ID_BITS,
    parameter int DELAY_BITS    = dtq_pkg::DEFAULT_DELAY_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // task_id [7:0], delay_ticks [23:8]
    input  wire logic [1:0]  s_axis_tuser,   // op [1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // popped_id [7:0], entry_count [12:8], zeros
    output logic [2:0]       m_axis_tuser    // status [2:0]
);

    localparam int SLOT_W = $clog2(QUEUE_ENTRIES);
    localparam int CNT_W  = $clog2(QUEUE_ENTRIES + 1);
    localparam int REM_W  = dtq_pkg::REM_W;

    typedef struct packed {
        logic [SLOT_W-1:0]                    link;
        logic [TASK_ID_BITS-1:0]              task_id;
        logic signed [dtq_pkg::DELTA_W-1:0]   delta;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    dtq_pkg::dtq_state_t  state_reg, state_next;
    dtq_pkg::dtq_op_t     op_reg, op_next;
    dtq_pkg::dtq_status_t res_status_reg, res_status_next;

    logic [TASK_ID_BITS-1:0] id_reg, id_next;
    logic [TASK_ID_BITS-1:0] res_id_reg, res_id_next;
    logic signed [REM_W-1:0] rem_reg, rem_next;
    logic [SLOT_W-1:0]       head_reg, head_next;
    logic [SLOT_W-1:0]       free_reg, free_next;
    logic [SLOT_W-1:0]       fresh_reg, fresh_next;
    logic [SLOT_W-1:0]       cur_reg, cur_next;
    logic [SLOT_W-1:0]       prev_reg, prev_next;
    logic [SLOT_W-1:0]       clr_reg, clr_next;
    entry_t                  prev_word_reg, prev_word_next;
    entry_t                  cur_word_reg, cur_word_next;
    logic                    has_prev_reg, has_prev_next;
    logic [CNT_W-1:0]        walk_k_reg, walk_k_next;
    logic [CNT_W-1:0]        count_reg, count_next;

    logic                    out_valid_reg;
    dtq_pkg::dtq_status_t    out_status_reg;
    logic [7:0]              out_id_reg;
    logic [4:0]              out_count_reg;
    logic                    out_load;

    logic                    mem_we;
    logic [SLOT_W-1:0]       mem_waddr;
    entry_t                  mem_wword;
    logic [SLOT_W-1:0]       mem_raddr;
    logic [ENTRY_W-1:0]      mem_rdata;
    entry_t                  rd_word;
    logic signed [REM_W-1:0] delta_ext;
    logic signed [REM_W-1:0] rem_after;

    dtq_ram #(
        .DEPTH  (QUEUE_ENTRIES),
        .WIDTH  (ENTRY_W),
        .ADDR_W (SLOT_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wword),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_word   = entry_t'(mem_rdata);
    assign delta_ext = REM_W'($signed(rd_word.delta));
    assign rem_after = rem_reg - delta_ext;

    assign s_axis_tready = (state_reg == dtq_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {3'b000, out_count_reg, out_id_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dtq_pkg::ST_CLEAR;
            head_reg      <= '0;
            free_reg      <= '0;
            count_reg     <= '0;
            clr_reg       <= '0;
            has_prev_reg  <= 1'b0;
            walk_k_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            free_reg     <= free_next;
            count_reg    <= count_next;
            clr_reg      <= clr_next;
            has_prev_reg <= has_prev_next;
            walk_k_reg   <= walk_k_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        id_reg         <= id_next;
        rem_reg        <= rem_next;
        fresh_reg      <= fresh_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        prev_word_reg  <= prev_word_next;
        cur_word_reg   <= cur_word_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_id_reg     <= 8'(res_id_reg);
            out_count_reg  <= 5'(count_reg);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        rem_next        = rem_reg;
        head_next       = head_reg;
        free_next       = free_reg;
        fresh_next      = fresh_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        clr_next        = clr_reg;
        prev_word_next  = prev_word_reg;
        cur_word_next   = cur_word_reg;
        has_prev_next   = has_prev_reg;
        walk_k_next     = walk_k_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        out_load        = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wword       = '0;
        mem_raddr       = '0;

        unique case (state_reg)
            dtq_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                if (clr_reg == SLOT_W'(QUEUE_ENTRIES - 1))
                begin
                    mem_wword.link = '0;
                    state_next     = dtq_pkg::ST_IDLE;
                end
                else
                begin
                    mem_wword.link = SLOT_W'(clr_reg + 1'b1);
                    clr_next       = SLOT_W'(clr_reg + 1'b1);
                end
            end

            dtq_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next     = dtq_pkg::dtq_op_t'(s_axis_tuser);
                    id_next     = TASK_ID_BITS'(s_axis_tdata[7:0]);
                    rem_next    = REM_W'(DELAY_BITS'(s_axis_tdata[23:8]));
                    res_id_next = '0;
                    unique case (s_axis_tuser)
                        dtq_pkg::OP_INSERT:
                        begin
                            if (count_reg == CNT_W'(QUEUE_ENTRIES))
                            begin
                                res_status_next = dtq_pkg::STAT_FULL;
                                state_next      = dtq_pkg::ST_RESP;
                            end
                            else
                            begin
                                mem_raddr  = free_reg;
                                fresh_next = free_reg;
                                state_next = dtq_pkg::ST_FRESH;
                            end
                        end
                        dtq_pkg::OP_TICK, dtq_pkg::OP_POP:
                        begin
                            if (count_reg != '0)
                            begin
                                mem_raddr  = head_reg;
                                state_next = dtq_pkg::ST_HEAD;
                            end
                            else
                            begin
                                res_status_next = (s_axis_tuser == dtq_pkg::OP_TICK) ?
                                                  dtq_pkg::STAT_TICKED : dtq_pkg::STAT_NONE;
                                state_next      = dtq_pkg::ST_RESP;
                            end
                        end
                        default:
                        begin
                            res_status_next = dtq_pkg::STAT_NONE;
                            state_next      = dtq_pkg::ST_RESP;
                        end
                    endcase
                end
            end

            dtq_pkg::ST_FRESH:
            begin
                free_next     = rd_word.link;
                walk_k_next   = '0;
                has_prev_next = 1'b0;
                if (count_reg == '0)
                begin
                    mem_we            = 1'b1;
                    mem_waddr         = fresh_reg;
                    mem_wword.delta   = dtq_pkg::sat_delta(rem_reg);
                    mem_wword.task_id = id_reg;
                    mem_wword.link    = '0;
                    head_next         = fresh_reg;
                    count_next        = CNT_W'(count_reg + 1'b1);
                    res_status_next   = dtq_pkg::STAT_INSERTED;
                    state_next        = dtq_pkg::ST_RESP;
                end
                else
                begin
                    mem_raddr  = head_reg;
                    cur_next   = head_reg;
                    state_next = dtq_pkg::ST_WALK;
                end
            end

            dtq_pkg::ST_WALK:
            begin
                if (delta_ext > rem_reg)
                begin
                    mem_we              = 1'b1;
                    mem_waddr           = fresh_reg;
                    mem_wword.delta     = dtq_pkg::sat_delta(rem_reg);
                    mem_wword.task_id   = id_reg;
                    mem_wword.link      = cur_reg;
                    cur_word_next       = rd_word;
                    cur_word_next.delta = dtq_pkg::sat_delta(delta_ext - rem_reg);
                    state_next          = dtq_pkg::ST_WR_CUR;
                end
                else
                begin
                    rem_next       = rem_after;
                    prev_next      = cur_reg;
                    prev_word_next = rd_word;
                    has_prev_next  = 1'b1;
                    if (walk_k_reg == CNT_W'(count_reg - 1'b1))
                    begin
                        mem_we            = 1'b1;
                        mem_waddr         = fresh_reg;
                        mem_wword.delta   = dtq_pkg::sat_delta(rem_after);
                        mem_wword.task_id = id_reg;
                        mem_wword.link    = '0;
                        state_next        = dtq_pkg::ST_WR_PREV;
                    end
                    else
                    begin
                        walk_k_next = CNT_W'(walk_k_reg + 1'b1);
                        mem_raddr   = rd_word.link;
                        cur_next    = rd_word.link;
                    end
                end
            end

            dtq_pkg::ST_WR_CUR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cur_reg;
                mem_wword = cur_word_reg;
                if (has_prev_reg)
                begin
                    state_next = dtq_pkg::ST_WR_PREV;
                end
                else
                begin
                    head_next       = fresh_reg;
                    count_next      = CNT_W'(count_reg + 1'b1);
                    res_status_next = dtq_pkg::STAT_INSERTED;
                    state_next      = dtq_pkg::ST_RESP;
                end
            end

            dtq_pkg::ST_WR_PREV:
            begin
                mem_we          = 1'b1;
                mem_waddr       = prev_reg;
                mem_wword       = prev_word_reg;
                mem_wword.link  = fresh_reg;
                count_next      = CNT_W'(count_reg + 1'b1);
                res_status_next = dtq_pkg::STAT_INSERTED;
                state_next      = dtq_pkg::ST_RESP;
            end

            dtq_pkg::ST_HEAD:
            begin
                state_next = dtq_pkg::ST_RESP;
                if (op_reg == dtq_pkg::OP_TICK)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = head_reg;
                    mem_wword       = rd_word;
                    mem_wword.delta = dtq_pkg::sat_delta(delta_ext - REM_W'(1));
                    res_status_next = dtq_pkg::STAT_TICKED;
                end
                else if (rd_word.delta < 0)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = head_reg;
                    mem_wword       = rd_word;
                    mem_wword.link  = free_reg;
                    free_next       = head_reg;
                    head_next       = rd_word.link;
                    count_next      = CNT_W'(count_reg - 1'b1);
                    res_id_next     = rd_word.task_id;
                    res_status_next = dtq_pkg::STAT_POPPED;
                end
                else
                begin
                    res_status_next = dtq_pkg::STAT_NONE;
                end
            end

            dtq_pkg::ST_RESP:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = dtq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = dtq_pkg::ST_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_ENTRIES))
        else $error("queued count exceeds the queue depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |->
            (count_reg == CNT_W'($past(count_reg) + 1'b1)) ||
            (CNT_W'(count_reg + 1'b1) == $past(count_reg)))
        else $error("queued count moved by more than one entry");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dtq_pkg::ST_IDLE || state_reg == dtq_pkg::ST_RESP) |-> !mem_we)
        else $error("entry memory written outside a command");

    a_walk_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dtq_pkg::ST_WALK |-> walk_k_reg < count_reg)
        else $error("insert walk ran past the queued entries");

    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("result beat lost after loading the output register");

endmodule

`default_nettype wire

>>> tb/sv/timer_queue_checker.sv
`timescale 1ns / 100ps
// Checker for the delta timer queue: tracks the queue contents and compares every result beat.
module timer_queue_checker #(
    parameter int QUEUE_ENTRIES = dtq_pkg::DEFAULT_QUEUE_ENTRIES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // task_id [7:0], delay_ticks [23:8]
    input  wire logic [1:0]  s_axis_tuser,   // op [1:0]
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [15:0] m_axis_tdata,   // popped_id [7:0], entry_count [12:8], zeros
    input  wire logic [2:0]  m_axis_tuser,   // status [2:0]
    output int               fail_count,
    output int               replies_due,
    output int               commands_seen,
    output int               replies_checked,
    output int               expirations_seen,
    output int               rejects_seen
);

    localparam int IDX_W = $clog2(QUEUE_ENTRIES);
    localparam longint DELTA_CEIL  = 64'sd8388607;
    localparam longint DELTA_FLOOR = -64'sd8388608;

    typedef struct packed {
        dtq_pkg::dtq_status_t status;
        logic [7:0]           popped_id;
        logic [4:0]           entry_count;
    } timer_reply_t;

    logic signed [23:0] slot_delta [QUEUE_ENTRIES];
    logic [7:0]         slot_task [QUEUE_ENTRIES];
    logic [IDX_W-1:0]   slot_next [QUEUE_ENTRIES];
    logic [IDX_W-1:0]   head_idx;
    logic [IDX_W-1:0]   free_idx;
    int                 queued;
    timer_reply_t       pending_replies [$];
    timer_reply_t       oldest_reply;
    timer_reply_t       new_reply;

    function automatic logic signed [23:0] clamp_delta(input longint v);
        if (v > DELTA_CEIL)
        begin
            return 24'(DELTA_CEIL);
        end
        if (v < DELTA_FLOOR)
        begin
            return 24'(DELTA_FLOOR);
        end
        return 24'(v);
    endfunction

    // The new entry lands before the first entry whose delta is strictly larger than
    // the delay still left, so it follows every entry that expires on the same tick.
    function automatic timer_reply_t advance_timer_queue(input logic [1:0] op,
                                                         input logic [7:0] id,
                                                         input logic [15:0] dly);
        timer_reply_t     reply;
        logic [IDX_W-1:0] fresh;
        logic [IDX_W-1:0] cur;
        logic [IDX_W-1:0] prev;
        logic             has_prev;
        logic             placed;
        longint           rem;
        reply.status    = dtq_pkg::STAT_NONE;
        reply.popped_id = '0;
        case (op)
            dtq_pkg::OP_INSERT:
            begin
                if (queued >= QUEUE_ENTRIES)
                begin
                    reply.status = dtq_pkg::STAT_FULL;
                end
                else
                begin
                    fresh = free_idx;
                    free_idx = slot_next[fresh];
                    slot_task[fresh] = id;
                    rem = longint'(dly);
                    cur = head_idx;
                    prev = '0;
                    has_prev = 1'b0;
                    placed = 1'b0;
                    for (int k = 0; k < queued && !placed; k++)
                    begin
                        if (longint'(slot_delta[cur]) > rem)
                        begin
                            placed = 1'b1;
                        end
                        else
                        begin
                            rem -= longint'(slot_delta[cur]);
                            prev = cur;
                            has_prev = 1'b1;
                            cur = slot_next[cur];
                        end
                    end
                    slot_delta[fresh] = clamp_delta(rem);
                    if (placed)
                    begin
                        slot_delta[cur] = clamp_delta(longint'(slot_delta[cur]) - rem);
                        slot_next[fresh] = cur;
                    end
                    else
                    begin
                        slot_next[fresh] = '0;
                    end
                    if (has_prev)
                    begin
                        slot_next[prev] = fresh;
                    end
                    else
                    begin
                        head_idx = fresh;
                    end
                    queued++;
                    reply.status = dtq_pkg::STAT_INSERTED;
                end
            end
            dtq_pkg::OP_TICK:
            begin
                if (queued > 0)
                begin
                    slot_delta[head_idx] = clamp_delta(longint'(slot_delta[head_idx]) - 1);
                end
                reply.status = dtq_pkg::STAT_TICKED;
            end
            dtq_pkg::OP_POP:
            begin
                if (queued > 0 && slot_delta[head_idx] < 0)
                begin
                    cur = head_idx;
                    reply.popped_id = slot_task[cur];
                    head_idx = slot_next[cur];
                    slot_next[cur] = free_idx;
                    free_idx = cur;
                    queued--;
                    reply.status = dtq_pkg::STAT_POPPED;
                end
            end
            default:
            begin
            end
        endcase
        reply.entry_count = 5'(queued);
        return reply;
    endfunction

    task automatic report_mismatch(input string detail);
        $display("[%0t] result beat %0d: %s", $time, replies_checked, detail);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QUEUE_ENTRIES; i++)
            begin
                slot_delta[i] = '0;
                slot_task[i] = '0;
                slot_next[i] = IDX_W'((i + 1) % QUEUE_ENTRIES);
            end
            head_idx = '0;
            free_idx = '0;
            queued = 0;
            pending_replies.delete();
            fail_count = 0;
            commands_seen = 0;
            replies_checked = 0;
            expirations_seen = 0;
            rejects_seen = 0;
            replies_due <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_replies.size() == 0)
                begin
                    report_mismatch($sformatf("arrived with nothing outstanding, status %0d",
                                              m_axis_tuser));
                end
                else
                begin
                    oldest_reply = pending_replies.pop_front();
                    if (m_axis_tuser !== oldest_reply.status)
                    begin
                        report_mismatch($sformatf("status %0d, wanted %0d",
                                                  m_axis_tuser, oldest_reply.status));
                    end
                    if (m_axis_tdata[7:0] !== oldest_reply.popped_id)
                    begin
                        report_mismatch($sformatf("popped_id %0d, wanted %0d",
                                                  m_axis_tdata[7:0], oldest_reply.popped_id));
                    end
                    if (m_axis_tdata[12:8] !== oldest_reply.entry_count)
                    begin
                        report_mismatch($sformatf("entry_count %0d, wanted %0d",
                                                  m_axis_tdata[12:8], oldest_reply.entry_count));
                    end
                end
                replies_checked++;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                new_reply = advance_timer_queue(s_axis_tuser, s_axis_tdata[7:0],
                                                s_axis_tdata[23:8]);
                if (new_reply.status == dtq_pkg::STAT_POPPED)
                begin
                    expirations_seen++;
                end
                if (new_reply.status == dtq_pkg::STAT_FULL)
                begin
                    rejects_seen++;
                end
                pending_replies.push_back(new_reply);
                commands_seen++;
            end
            replies_due <= pending_replies.size();
        end
    end

endmodule

>>> tb/sv/delta_timer_queue_unit_test.sv
`timescale 1ns / 100ps
// Testbench top for the delta timer queue: command stimulus, beat pacing and the verdict.
module delta_timer_queue_unit_test;

    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam int RANDOM_COMMANDS = 800;
    localparam int IDLE_LIMIT      = 2000;
    localparam int TAIL_CYCLES     = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [23:0] s_axis_tdata = '0;    // task_id [7:0], delay_ticks [23:8]
    logic [1:0]  s_axis_tuser = '0;    // op [1:0]
    logic        m_axis_tready = 1'b0;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [15:0] m_axis_tdata;         // popped_id [7:0], entry_count [12:8], zeros
    wire  [2:0]  m_axis_tuser;         // status [2:0]

    int fail_count;
    int replies_due;
    int commands_seen;
    int replies_checked;
    int expirations_seen;
    int rejects_seen;

    int          burst_left = 0;
    bit          tx_steady = 1'b0;
    int          idle_cycles = 0;
    int          rx_phase = 0;
    int          rx_mode = 0;
    logic [15:0] stall_pattern = '1;

    delta_timer_queue_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    timer_queue_checker u_checker (.*);

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // The receiver switches at each rx_phase rollover between always ready, mostly ready,
    // an even mix and mostly stalled, replaying a random 16-bit ready pattern.
    always @(posedge clk)
    begin
        if (rx_phase == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            case (rx_mode)
                0: stall_pattern = '1;
                1: stall_pattern = 16'($urandom) | 16'($urandom);
                2: stall_pattern = 16'($urandom);
                default: stall_pattern = 16'($urandom) & 16'($urandom);
            endcase
            rx_phase = 64;
        end
        m_axis_tready <= stall_pattern[0];
        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        rx_phase--;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("No beat moved for %0d cycles.", IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_command(input logic [1:0] op, input logic [7:0] id,
                                input logic [15:0] dly);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if (!tx_steady)
            begin
                gap = $urandom_range(1, 8);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {dly, id};
        s_axis_tuser <= op;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        int          counted;
        int          roll;
        int          insert_share;
        int          tick_share;
        bit          filling;
        logic [1:0]  op;
        logic [7:0]  id;
        logic [15:0] dly;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send_command(dtq_pkg::OP_POP, 8'h00, 16'h0000);
        send_command(dtq_pkg::OP_TICK, 8'hFF, 16'hFFFF);
        send_command(OP_RESERVED, 8'h5A, 16'h1234);
        send_command(dtq_pkg::OP_INSERT, 8'hFF, 16'h0000);
        send_command(dtq_pkg::OP_INSERT, 8'h00, 16'hFFFF);
        send_command(dtq_pkg::OP_INSERT, 8'hA5, 16'd3);
        send_command(dtq_pkg::OP_INSERT, 8'h5A, 16'd3);
        send_command(dtq_pkg::OP_INSERT, 8'h01, 16'd0);
        send_command(dtq_pkg::OP_POP, 8'h00, 16'h0000);
        send_command(dtq_pkg::OP_TICK, 8'h00, 16'h0000);
        send_command(dtq_pkg::OP_POP, 8'h00, 16'h0000);
        send_command(dtq_pkg::OP_POP, 8'h00, 16'h0000);
        for (int k = 0; k < 12; k++)
        begin
            send_command(dtq_pkg::OP_INSERT, 8'(8'h10 + k), 16'((k * 7) % 5));
        end
        send_command(dtq_pkg::OP_INSERT, 8'hC3, 16'd7);

        counted = 0;
        filling = 1'b0;
        while (counted < RANDOM_COMMANDS)
        begin
            if (counted % 100 == 0)
            begin
                filling = !filling;
            end
            insert_share = filling ? 50 : 15;
            tick_share = filling ? 30 : 50;
            roll = $urandom_range(0, 99);
            id = 8'($urandom);
            dly = 16'($urandom);
            if (roll < insert_share)
            begin
                op = dtq_pkg::OP_INSERT;
                roll = $urandom_range(0, 99);
                if (roll < 75)
                begin
                    dly = 16'($urandom_range(0, 12));
                end
                else if (roll < 99)
                begin
                    dly = 16'($urandom_range(0, 120));
                end
            end
            else if (roll < insert_share + tick_share)
            begin
                op = dtq_pkg::OP_TICK;
            end
            else if (roll < 95)
            begin
                op = dtq_pkg::OP_POP;
            end
            else
            begin
                op = OP_RESERVED;
            end
            send_command(op, id, dly);
            if (op != OP_RESERVED)
            begin
                counted++;
            end
            if ($urandom_range(0, 49) == 0)
            begin
                tx_steady = !tx_steady;
            end
        end
        s_axis_tvalid <= 1'b0;

        @(posedge clk);
        while (replies_due != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d command beats and checked %0d result beats.",
                 commands_seen, replies_checked);
        $display("Timers expired and popped: %0d; inserts refused by a full queue: %0d.",
                 expirations_seen, rejects_seen);
        if (fail_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
